/* hw/rtl/wsdf_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

   // Default width of the payload byte counter.
   localparam int LENGTH_WIDTH_DEFAULT = 64;

   // Header byte 1 layout.
   localparam logic [7:0] MASK_BIT_SEL   = 8'h80;
   localparam logic [7:0] LEN_CODE_SEL   = 8'h7F;

   // Length codes that announce an extended length field.
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   // Header sizes in bytes.
   localparam logic [3:0] HDR_BASE_BYTES  = 4'd2;
   localparam logic [3:0] HDR_EXT16_BYTES = 4'd2;
   localparam logic [3:0] HDR_EXT64_BYTES = 4'd8;
   localparam logic [3:0] HDR_KEY_BYTES   = 4'd4;

   // Header byte positions with a special meaning.
   localparam logic [3:0] HDR_IDX_LEN     = 4'd1;
   localparam logic [3:0] HDR_IDX_EXT     = 4'd2;

   // One result transaction.
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       last_of_frame;
      logic       empty_frame;
   } result_type;

endpackage

/* hw/rtl/websocket_frame_deframer.sv */
// WebSocket frame deframer: strips frame headers and unmasks payload bytes.
//
//   channel | direction | ports                                      | moves
//   --------+-----------+--------------------------------------------+-------------------------
//   req     | in        | req_valid, req_ready, req_link_byte        | one link byte
//   rsp     | out       | rsp_valid, rsp_ready, rsp_payload_byte,    | one payload byte or an
//           |           | rsp_last_of_frame, rsp_empty_frame         | empty-frame marker
//
// The block sustains one link byte per clock while req_ready is high.
// A payload byte is registered in the output stage before it leaves as a response
// transaction. Header bytes produce no response, except the last header byte of a
// zero-length frame, which produces the empty-frame marker.
// A two-entry output stage (main register plus skid register) lets a byte be taken
// while an earlier result still waits; req_ready drops only when both entries are full.
// Reset (synchronous, active high) returns the parser to the start of a header and
// empties the output stage.
module websocket_frame_deframer
   import wsdf_pkg::*;
#(
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_link_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last_of_frame,
   output logic       rsp_empty_frame
);

   // Largest length the payload counter can hold; longer frames saturate to it.
   localparam logic [63:0] LenMax = (LENGTH_WIDTH >= 64) ? {64{1'b1}} :
                                    ((64'd1 << LENGTH_WIDTH) - 64'd1);

   // Parser state.
   logic [3:0]              header_count_ff,  header_count_in;
   logic [3:0]              header_total_ff,  header_total_in;
   logic [6:0]              length_code_ff,   length_code_in;
   logic                    mask_on_ff,       mask_on_in;
   logic [63:0]             length_accum_ff,  length_accum_in;
   logic [31:0]             mask_key_ff,      mask_key_in;
   logic [LENGTH_WIDTH-1:0] payload_left_ff,  payload_left_in;
   logic [1:0]              mask_phase_ff,    mask_phase_in;
   logic                    in_payload_ff,    in_payload_in;

   // Output stage.
   logic       out_valid_ff,  out_valid_in;
   result_type out_data_ff,   out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff,  skid_data_in;

   // Result of the byte being taken this cycle.
   logic       res_valid;
   result_type res_data;

   logic       take;
   logic       push;

   // Helpers for the header path.
   logic [3:0]              ext_bytes;
   logic [3:0]              ext_bytes_new;
   logic [3:0]              idx_next;
   logic [7:0]              key_byte;
   logic [LENGTH_WIDTH-1:0] frame_len;
   logic                    len_overflow;

   assign req_ready = !skid_valid_ff;
   assign take      = req_valid && req_ready;
   assign push      = take && res_valid;

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_byte  = out_data_ff.payload_byte;
   assign rsp_last_of_frame = out_data_ff.last_of_frame;
   assign rsp_empty_frame   = out_data_ff.empty_frame;

   // Extended length size as announced by the stored length code, and as announced
   // by the byte arriving now (used on header byte 1).
   always_comb begin
      if (length_code_ff == LEN_CODE_EXT16) begin
         ext_bytes = HDR_EXT16_BYTES;
      end else if (length_code_ff == LEN_CODE_EXT64) begin
         ext_bytes = HDR_EXT64_BYTES;
      end else begin
         ext_bytes = 4'd0;
      end
      if ((req_link_byte & LEN_CODE_SEL) == {1'b0, LEN_CODE_EXT16}) begin
         ext_bytes_new = HDR_EXT16_BYTES;
      end else if ((req_link_byte & LEN_CODE_SEL) == {1'b0, LEN_CODE_EXT64}) begin
         ext_bytes_new = HDR_EXT64_BYTES;
      end else begin
         ext_bytes_new = 4'd0;
      end
   end

   // The first key byte sits in the top byte of the key register.
   always_comb begin
      case (mask_phase_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   // Parser next state and result for the byte being taken.
   always_comb begin
      header_count_in = header_count_ff;
      header_total_in = header_total_ff;
      length_code_in  = length_code_ff;
      mask_on_in      = mask_on_ff;
      length_accum_in = length_accum_ff;
      mask_key_in     = mask_key_ff;
      payload_left_in = payload_left_ff;
      mask_phase_in   = mask_phase_ff;
      in_payload_in   = in_payload_ff;
      res_valid       = 1'b0;
      res_data        = '0;
      idx_next        = header_count_ff + 4'd1;
      len_overflow    = 1'b0;
      frame_len       = '0;

      if (in_payload_ff) begin
         // Payload byte: unmask, count down, close the frame on the last byte.
         mask_phase_in   = mask_phase_ff + 2'd1;
         payload_left_in = payload_left_ff - 1'b1;
         res_valid       = 1'b1;
         res_data.payload_byte  = mask_on_ff ? (req_link_byte ^ key_byte) : req_link_byte;
         res_data.last_of_frame = (payload_left_in == '0);
         if (payload_left_in == '0) begin
            header_count_in = 4'd0;
            header_total_in = HDR_BASE_BYTES;
            in_payload_in   = 1'b0;
         end
      end else begin
         if (header_count_ff == HDR_IDX_LEN) begin
            length_code_in  = req_link_byte[6:0];
            mask_on_in      = |(req_link_byte & MASK_BIT_SEL);
            header_total_in = HDR_BASE_BYTES + ext_bytes_new +
                              (mask_on_in ? HDR_KEY_BYTES : 4'd0);
            length_accum_in = '0;
            mask_key_in     = '0;
         end else if (header_count_ff >= HDR_IDX_EXT) begin
            if (header_count_ff < (HDR_BASE_BYTES + ext_bytes)) begin
               length_accum_in = {length_accum_ff[55:0], req_link_byte};
            end else begin
               mask_key_in = {mask_key_ff[23:0], req_link_byte};
            end
         end
         header_count_in = idx_next;

         // Header complete: load the payload counter, saturating long lengths.
         len_overflow = |(length_accum_in & ~LenMax);
         if (length_code_in < LEN_CODE_EXT16) begin
            frame_len = LENGTH_WIDTH'(length_code_in);
         end else if (len_overflow) begin
            frame_len = LenMax[LENGTH_WIDTH-1:0];
         end else begin
            frame_len = length_accum_in[LENGTH_WIDTH-1:0];
         end

         if ((header_count_ff >= HDR_IDX_LEN) && (idx_next == header_total_in)) begin
            payload_left_in = frame_len;
            mask_phase_in   = 2'd0;
            header_count_in = 4'd0;
            if (frame_len == '0) begin
               // Zero-length frame: emit the empty marker and expect the next header.
               header_total_in        = HDR_BASE_BYTES;
               in_payload_in          = 1'b0;
               res_valid              = 1'b1;
               res_data.last_of_frame = 1'b1;
               res_data.empty_frame   = 1'b1;
            end else begin
               in_payload_in = 1'b1;
            end
         end
      end
   end

   // Output stage: the skid register fills only while the main register is stalled.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && !rsp_ready) begin
         if (push) begin
            skid_valid_in = 1'b1;
            skid_data_in  = res_data;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = push;
         skid_data_in  = res_data;
      end else begin
         out_valid_in = push;
         out_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff <= 4'd0;
         header_total_ff <= HDR_BASE_BYTES;
         length_code_ff  <= 7'd0;
         mask_on_ff      <= 1'b0;
         length_accum_ff <= '0;
         mask_key_ff     <= '0;
         payload_left_ff <= '0;
         mask_phase_ff   <= 2'd0;
         in_payload_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (take) begin
            header_count_ff <= header_count_in;
            header_total_ff <= header_total_in;
            length_code_ff  <= length_code_in;
            mask_on_ff      <= mask_on_in;
            length_accum_ff <= length_accum_in;
            mask_key_ff     <= mask_key_in;
            payload_left_ff <= payload_left_in;
            mask_phase_ff   <= mask_phase_in;
            in_payload_ff   <= in_payload_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers of the output stage need no reset.
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the WebSocket frame deframer.
`timescale 1ns / 100ps

module testbench;
   import wsdf_pkg::*;

   // The testbench predicts with the same counter width that the block is built with.
   localparam int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT;
   localparam logic [63:0] LEN_MAX = (LENGTH_WIDTH >= 64) ? {64{1'b1}}
                                                          : ((64'd1 << LENGTH_WIDTH) - 64'd1);
   localparam int RANDOM_ITEMS = 650;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 200000;

   // Receiver behaviors; each one holds for a random stretch of cycles.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_EVERY_FOURTH,
      READY_SPARSE
   } ready_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_link_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_last_of_frame;
   logic       rsp_empty_frame;

   // Link bytes waiting to be offered, and payload results the block still owes us.
   logic [7:0] link_bytes_pending[$];
   result_type expected_results[$];
   result_type oldest_result;

   // Shadow of the deframer's parser state, kept in step with every accepted byte.
   logic [3:0]  hdr_count;
   logic [3:0]  hdr_total;
   logic [6:0]  len_code;
   logic        mask_set;
   logic [63:0] ext_length;
   logic [31:0] unmask_key;
   logic [63:0] bytes_left;
   logic [1:0]  key_phase;
   logic        in_data;

   int          cycle_count = 0;
   int          mismatch_count = 0;
   int          results_checked = 0;
   int          empty_markers = 0;
   int          frames_built = 0;
   int          bytes_accepted = 0;
   logic        req_fired = 1'b0;
   int          burst_left = 1;
   int          gap_left = 0;
   int          mode_left = 0;
   ready_mode_type ready_mode = READY_ALWAYS;

   websocket_frame_deframer #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_link_byte    (req_link_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last_of_frame(rsp_last_of_frame),
      .rsp_empty_frame  (rsp_empty_frame)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Number of extended length bytes that a length code announces.
   function automatic logic [3:0] ext_field_bytes(input logic [6:0] code);
      if (code == LEN_CODE_EXT16) begin
         return HDR_EXT16_BYTES;
      end else if (code == LEN_CODE_EXT64) begin
         return HDR_EXT64_BYTES;
      end
      return 4'd0;
   endfunction

   // Advances the shadow parser by one link byte and queues the result it causes, if any.
   task automatic deframe_link_byte(input logic [7:0] link_byte);
      logic [7:0] key_byte;
      logic [3:0] idx;
      logic [3:0] ext;
      logic [63:0] frame_length;
      result_type outcome;
      if (in_data) begin
         // Payload byte: unmask with the key byte at this position, if the frame is masked.
         key_byte = mask_set ? 8'(unmask_key >> (24 - 8 * key_phase)) : 8'h00;
         key_phase = key_phase + 2'd1;
         bytes_left = bytes_left - 64'd1;
         outcome.payload_byte  = link_byte ^ key_byte;
         outcome.last_of_frame = (bytes_left == 64'd0);
         outcome.empty_frame   = 1'b0;
         if (outcome.last_of_frame) begin
            hdr_count = 4'd0;
            hdr_total = HDR_BASE_BYTES;
            in_data   = 1'b0;
         end
         expected_results.push_back(outcome);
      end else begin
         idx = hdr_count;
         ext = ext_field_bytes(len_code);
         if (idx == HDR_IDX_LEN) begin
            len_code   = 7'(link_byte & LEN_CODE_SEL);
            mask_set   = (link_byte & MASK_BIT_SEL) != 8'h00;
            ext        = ext_field_bytes(len_code);
            hdr_total  = HDR_BASE_BYTES + ext + (mask_set ? HDR_KEY_BYTES : 4'd0);
            ext_length = 64'd0;
            unmask_key = 32'd0;
         end else if (idx >= HDR_IDX_EXT) begin
            if (idx < HDR_BASE_BYTES + ext) begin
               ext_length = {ext_length[55:0], link_byte};
            end else begin
               unmask_key = {unmask_key[23:0], link_byte};
            end
         end
         hdr_count = idx + 4'd1;
         if (idx >= HDR_IDX_LEN && hdr_count == hdr_total) begin
            if (len_code < LEN_CODE_EXT16) begin
               frame_length = 64'(len_code);
            end else if (ext_length > LEN_MAX) begin
               frame_length = LEN_MAX;
            end else begin
               frame_length = ext_length;
            end
            bytes_left = frame_length;
            key_phase  = 2'd0;
            if (frame_length == 64'd0) begin
               // A zero-length frame ends at its header with one empty marker.
               hdr_count = 4'd0;
               hdr_total = HDR_BASE_BYTES;
               in_data   = 1'b0;
               outcome.payload_byte  = 8'h00;
               outcome.last_of_frame = 1'b1;
               outcome.empty_frame   = 1'b1;
               expected_results.push_back(outcome);
            end else begin
               hdr_count = 4'd0;
               in_data   = 1'b1;
            end
         end
      end
   endtask

   // Queues one frame header and then data_count random payload bytes.
   task automatic push_frame(input logic [7:0] first_byte, input logic masked,
                             input logic [6:0] code, input logic [63:0] long_length,
                             input logic [31:0] key_value, input int data_count);
      int ext;
      ext = int'(ext_field_bytes(code));
      link_bytes_pending.push_back(first_byte);
      link_bytes_pending.push_back({masked, code});
      for (int i = ext - 1; i >= 0; i--) begin
         link_bytes_pending.push_back(long_length[8 * i +: 8]);
      end
      if (masked) begin
         for (int i = 3; i >= 0; i--) begin
            link_bytes_pending.push_back(key_value[8 * i +: 8]);
         end
      end
      for (int i = 0; i < data_count; i++) begin
         link_bytes_pending.push_back(8'($urandom));
      end
      frames_built++;
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Driver. The sender works in bursts with random gaps in between. A byte that has
   // been offered stays on the port, unchanged, until its transaction completes.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && !req_fired) begin
            // Still waiting for the block to take the current byte.
         end else if (gap_left > 0) begin
            gap_left  = gap_left - 1;
            req_valid <= 1'b0;
         end else if (link_bytes_pending.size() > 0) begin
            req_valid     <= 1'b1;
            req_link_byte <= link_bytes_pending[0];
            if (burst_left <= 1) begin
               // Start a new burst; a quarter of the time there is no gap at all.
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end

         // The receiver switches among its stall behaviors every so many cycles.
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 150);
         end else begin
            mode_left = mode_left - 1;
         end
         case (ready_mode)
            READY_ALWAYS:       rsp_ready <= 1'b1;
            READY_COIN:         rsp_ready <= 1'($urandom_range(0, 1));
            READY_EVERY_FOURTH: rsp_ready <= (cycle_count % 4 == 0);
            READY_SPARSE:       rsp_ready <= ($urandom_range(0, 7) == 0);
            default:            rsp_ready <= 1'b1;
         endcase
      end
   end

   // Monitor and scoreboard. The result channel is checked before the request side
   // is predicted, so a byte taken at this edge cannot be confused with a result
   // leaving at the same edge; its own result is registered in the output stage first.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("websocket_frame_deframer regression: fail");
         $finish;
      end else begin
         req_fired <= !reset && req_valid && req_ready;
         if (!reset) begin
            if (rsp_valid && rsp_ready) begin
               if (expected_results.size() == 0) begin
                  $error("unexpected result transaction: payload_byte %0h last %0b empty %0b",
                         rsp_payload_byte, rsp_last_of_frame, rsp_empty_frame);
                  mismatch_count++;
               end else begin
                  oldest_result = expected_results.pop_front();
                  check_field("payload_byte", oldest_result.payload_byte, rsp_payload_byte);
                  check_field("last_of_frame", 8'(oldest_result.last_of_frame),
                              8'(rsp_last_of_frame));
                  check_field("empty_frame", 8'(oldest_result.empty_frame),
                              8'(rsp_empty_frame));
                  results_checked++;
                  if (oldest_result.empty_frame) begin
                     empty_markers++;
                  end
               end
            end
            if (req_valid && req_ready) begin
               deframe_link_byte(req_link_byte);
               void'(link_bytes_pending.pop_front());
               bytes_accepted++;
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int directed_bytes;
      int sel;
      logic [6:0] code;
      logic [63:0] long_length;
      int data_count;

      // The shadow parser starts where the block's reset leaves it.
      hdr_count  = 4'd0;
      hdr_total  = HDR_BASE_BYTES;
      len_code   = 7'd0;
      mask_set   = 1'b0;
      ext_length = 64'd0;
      unmask_key = 32'd0;
      bytes_left = 64'd0;
      key_phase  = 2'd0;
      in_data    = 1'b0;

      // Directed frames: an unmasked empty frame, a masked empty frame whose key must
      // be ignored, a short masked frame with payload extremes, and a 64-bit length
      // field that encodes zero.
      push_frame(8'h81, 1'b0, 7'd0, 64'd0, 32'h0000_0000, 0);
      push_frame(8'h00, 1'b1, 7'd0, 64'd0, 32'hFFFF_FFFF, 0);
      push_frame(8'hFF, 1'b1, 7'd2, 64'd0, 32'hAA55_F00F, 0);
      link_bytes_pending.push_back(8'h00);
      link_bytes_pending.push_back(8'hFF);
      push_frame(8'h82, 1'b0, LEN_CODE_EXT64, 64'd0, 32'h0, 0);
      directed_bytes = link_bytes_pending.size();

      // Random frames, mostly short and well formed with random content. Extended
      // lengths are often not minimally encoded, and some headers are pure noise.
      while (link_bytes_pending.size() - directed_bytes < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         long_length = 64'd0;
         if (sel < 45) begin
            code = 7'($urandom_range(0, 12));
         end else if (sel < 50) begin
            code = 7'($urandom_range(100, 125));
         end else if (sel < 70) begin
            code = LEN_CODE_EXT16;
            long_length = 64'($urandom_range(0, 40));
         end else if (sel < 72) begin
            code = LEN_CODE_EXT16;
            long_length = 64'($urandom_range(256, 300));
         end else if (sel < 87) begin
            code = LEN_CODE_EXT64;
            long_length = 64'($urandom_range(0, 30));
         end else if (sel < 90) begin
            code = 7'd0;
         end else begin
            code = 7'($urandom_range(0, 127));
            long_length = 64'($urandom_range(0, 255));
         end
         data_count = (code < LEN_CODE_EXT16) ? int'(code) : int'(long_length);
         push_frame(8'($urandom), 1'($urandom_range(0, 1)), code, long_length, $urandom,
                    data_count);
      end

      // Close with a masked frame whose 64-bit length has the reserved top bit set;
      // it never completes, so every byte after its header is ordinary payload.
      push_frame(8'($urandom), 1'b1, LEN_CODE_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, 24);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (link_bytes_pending.size() != 0 || expected_results.size() != 0) begin
         @(posedge clock);
      end
      // Give any stray result time to show up.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d frames in %0d link bytes, with bursty sending and stalls.",
               frames_built, bytes_accepted);
      $display("Checked %0d result transactions, %0d of them empty-frame markers.",
               results_checked, empty_markers);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("websocket_frame_deframer regression: pass");
      end else begin
         $display("websocket_frame_deframer regression: fail");
      end
      $finish;
   end

endmodule
